// File: hw/rtl/mefd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mefd_pkg;

  // Encoder and angle scaling
  localparam int ENC_MAX   = 8191;
  localparam int FULL_TURN = 92160;
  localparam int HALF_TURN = 46080;
  localparam int CNT_W     = $clog2(ENC_MAX + 1);
  localparam int ANG_W     = 17;
  localparam int DLT_W     = 17;

  // Dividend of the angle scaling: count * FULL_TURN + ENC_MAX / 2
  localparam int N_W = $clog2(longint'(ENC_MAX) * FULL_TURN + ENC_MAX / 2 + 1);

  // Reciprocal of ENC_MAX; exact floor for every dividend below 2**N_W
  localparam int              DIV_SHIFT = N_W + CNT_W;
  localparam int              R_W       = N_W + 2;
  localparam logic [R_W-1:0]  DIV_RECIP = R_W'((64'd1 << DIV_SHIFT) / ENC_MAX + 64'd1);

  // Gear ratio, Q0.16
  localparam int              RATIO_W     = 16;
  localparam logic [15:0]     RATIO_RESET = 16'd3413;
  localparam logic [32:0]     RATIO_HALF  = 33'd32768;

  // Multi-turn accumulator
  localparam int ACC_W = 48;
  localparam int TOT_W = 48;

  // Current mapping
  localparam int CUR_LIMIT   = 16384;
  localparam int CUR_FULL_MA = 20000;
  localparam int CUR_SHIFT   = $clog2(CUR_LIMIT);
  localparam int CURMAG_W    = $clog2(CUR_LIMIT + 1);
  localparam int CURPRD_W    = $clog2(longint'(CUR_LIMIT) * CUR_FULL_MA + CUR_LIMIT / 2 + 1);

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [CNT_W-1:0]    count;
    logic signed [15:0]  speed;
    logic                cur_neg;
    logic [CURMAG_W-1:0] cur_mag;
    logic [7:0]          temp;
  } mefd_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_UNW,
    ST_ACC
  } mefd_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/motor_encoder_feedback_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_frame_byte0..6, 8 bits each
// out_      output     out_valid/out_stall  rotor angle, deltas, shaft total, speed,
//                                           current, temperature
// cfg_      input      cfg_wr_en            cfg_wr_data: reciprocal gear ratio, Q0.16
//
// In the back end each frame goes through load, reciprocal multiply for the
// angle scaling, unwrap with the gear multiply, then accumulate into the output register.
// A two-entry queue takes frames in while the back end works or the output waits.
// Reset is synchronous: state, accumulator and previous angle clear, ratio returns to 3413.
// in_stall rises only when the queue is full; the result holds while out_stall is high.
module motor_encoder_feedback_decoder_unit
  import mefd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [15:0]        cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_frame_byte0,
  input  wire logic [7:0]         in_frame_byte1,
  input  wire logic [7:0]         in_frame_byte2,
  input  wire logic [7:0]         in_frame_byte3,
  input  wire logic [7:0]         in_frame_byte4,
  input  wire logic [7:0]         in_frame_byte5,
  input  wire logic [7:0]         in_frame_byte6,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [16:0]             out_rotor_angle,
  output logic signed [16:0]      out_rotor_delta,
  output logic signed [16:0]      out_shaft_delta,
  output logic signed [47:0]      out_shaft_angle_total,
  output logic signed [15:0]      out_speed_rpm,
  output logic signed [15:0]      out_current_ma,
  output logic [7:0]              out_temperature
);

  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_valid;
  mefd_entry_t push_entry;
  mefd_entry_t head_entry;

  // Saturate the count, clamp the current and pack the frame
  mefd_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_frame_byte0 (in_frame_byte0),
    .in_frame_byte1 (in_frame_byte1),
    .in_frame_byte2 (in_frame_byte2),
    .in_frame_byte3 (in_frame_byte3),
    .in_frame_byte4 (in_frame_byte4),
    .in_frame_byte5 (in_frame_byte5),
    .in_frame_byte6 (in_frame_byte6),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (push_entry)
  );

  // Decouple front and back
  mefd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (head_entry)
  );

  // Scale, unwrap and accumulate
  mefd_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .q_valid               (q_valid),
    .q_entry               (head_entry),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_rotor_angle       (out_rotor_angle),
    .out_rotor_delta       (out_rotor_delta),
    .out_shaft_delta       (out_shaft_delta),
    .out_shaft_angle_total (out_shaft_angle_total),
    .out_speed_rpm         (out_speed_rpm),
    .out_current_ma        (out_current_ma),
    .out_temperature       (out_temperature)
  );

endmodule

`default_nettype wire

// File: hw/rtl/mefd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mefd_front
  import mefd_pkg::*;
(
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_frame_byte0,
  input  wire logic [7:0]  in_frame_byte1,
  input  wire logic [7:0]  in_frame_byte2,
  input  wire logic [7:0]  in_frame_byte3,
  input  wire logic [7:0]  in_frame_byte4,
  input  wire logic [7:0]  in_frame_byte5,
  input  wire logic [7:0]  in_frame_byte6,
  input  wire logic        q_full,
  output logic             q_push,
  output mefd_entry_t      q_entry
);

  logic [15:0]        raw_count;
  logic [15:0]        cur_raw;
  logic               cur_neg;
  logic [16:0]        cur_abs;
  logic [CNT_W-1:0]   count_sat;
  logic [CURMAG_W-1:0] cur_mag;

  // Hold the input while the queue is full
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Saturate the encoder count
  assign raw_count = {in_frame_byte0, in_frame_byte1};
  assign count_sat = (raw_count > 16'(ENC_MAX)) ? CNT_W'(ENC_MAX) : raw_count[CNT_W-1:0];

  // Split current into sign and clamped magnitude
  assign cur_raw = {in_frame_byte4, in_frame_byte5};
  assign cur_neg = cur_raw[15];
  assign cur_abs = cur_neg ? (17'd0 - {1'b1, cur_raw}) : {1'b0, cur_raw};
  assign cur_mag = (cur_abs > 17'(CUR_LIMIT)) ? CURMAG_W'(CUR_LIMIT) : cur_abs[CURMAG_W-1:0];

  // Pack the beat for the back end
  always_comb begin
    q_entry.count   = count_sat;
    q_entry.speed   = $signed({in_frame_byte2, in_frame_byte3});
    q_entry.cur_neg = cur_neg;
    q_entry.cur_mag = cur_mag;
    q_entry.temp    = in_frame_byte6;
  end

endmodule

`default_nettype wire

// File: hw/rtl/mefd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mefd_queue
  import mefd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire mefd_entry_t push_entry,
  output logic             full,
  input  wire logic        pop,
  output logic             head_valid,
  output mefd_entry_t      head_entry
);

  mefd_entry_t       slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_entry = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mefd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mefd_back
  import mefd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [15:0]        cfg_wr_data,
  input  wire logic               q_valid,
  input  wire mefd_entry_t        q_entry,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [ANG_W-1:0]        out_rotor_angle,
  output logic signed [DLT_W-1:0] out_rotor_delta,
  output logic signed [DLT_W-1:0] out_shaft_delta,
  output logic signed [TOT_W-1:0] out_shaft_angle_total,
  output logic signed [15:0]      out_speed_rpm,
  output logic signed [15:0]      out_current_ma,
  output logic [7:0]              out_temperature
);

  mefd_state_t state_r, state_nxt;
  logic        load;

  logic [RATIO_W-1:0]         ratio_r;
  logic [ANG_W-1:0]           prev_r;
  logic signed [ACC_W-1:0]    acc_r;

  logic [N_W-1:0]             n_r;
  logic [N_W+R_W-1:0]         prod_r;
  logic signed [15:0]         speed_r;
  logic                       cur_neg_r;
  logic [CURMAG_W-1:0]        cur_mag_r;
  logic [7:0]                 temp_r;
  logic signed [15:0]         cur_ma_r;
  logic [ANG_W-1:0]           angle_r;
  logic signed [DLT_W-1:0]    delta_r;
  logic                       dneg_r;
  logic [31:0]                sprod_r;

  logic                       out_valid_r;
  logic [ANG_W-1:0]           out_angle_r;
  logic signed [DLT_W-1:0]    out_delta_r;
  logic signed [DLT_W-1:0]    out_shaft_r;
  logic signed [TOT_W-1:0]    out_total_r;
  logic signed [15:0]         out_speed_r;
  logic signed [15:0]         out_cur_r;
  logic [7:0]                 out_temp_r;

  logic [N_W-1:0]             n_nxt;
  logic [CURPRD_W-1:0]        cur_prod;
  logic [CURPRD_W-1:0]        cur_mag_ma;
  logic [ANG_W-1:0]           angle;
  logic signed [ANG_W:0]      diff;
  logic signed [ANG_W:0]      diff_unw;
  logic [DLT_W-1:0]           dmag;
  logic [32:0]                sround;
  logic [DLT_W-1:0]           smag;
  logic signed [DLT_W-1:0]    shaft;
  logic signed [ACC_W:0]      acc_sum;
  logic signed [ACC_W-1:0]    acc_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (q_valid) state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_UNW;
      ST_UNW:  state_nxt = ST_ACC;
      ST_ACC:  if (load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop = 1'b0;
    load  = 1'b0;
    case (state_r)
      ST_IDLE: q_pop = q_valid;
      ST_ACC:  load  = !out_valid_r || !out_stall;
      default: begin
        q_pop = 1'b0;
        load  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Scale the count: dividend of count * FULL_TURN / ENC_MAX, rounded
  assign n_nxt = N_W'(q_entry.count) * N_W'(FULL_TURN) + N_W'(ENC_MAX / 2);

  // Map current magnitude to mA, rounded
  assign cur_prod   = CURPRD_W'(cur_mag_r) * CURPRD_W'(CUR_FULL_MA) + CURPRD_W'(CUR_LIMIT / 2);
  assign cur_mag_ma = cur_prod >> CUR_SHIFT;

  // Take the quotient and unwrap the change
  assign angle = prod_r[DIV_SHIFT +: ANG_W];
  assign diff  = $signed({1'b0, angle}) - $signed({1'b0, prev_r});
  always_comb begin
    diff_unw = diff;
    if (diff > $signed((ANG_W+1)'(HALF_TURN))) begin
      diff_unw = diff - $signed((ANG_W+1)'(FULL_TURN));
    end else if (diff < -$signed((ANG_W+1)'(HALF_TURN))) begin
      diff_unw = diff + $signed((ANG_W+1)'(FULL_TURN));
    end
  end
  assign dmag = diff_unw[ANG_W] ? DLT_W'(-diff_unw) : DLT_W'(diff_unw);

  // Round the geared change and saturate the accumulator
  assign sround  = {1'b0, sprod_r} + RATIO_HALF;
  assign smag    = sround[32:16];
  assign shaft   = dneg_r ? -$signed(smag) : $signed(smag);
  assign acc_sum = {acc_r[ACC_W-1], acc_r} + (ACC_W+1)'(shaft);
  always_comb begin
    acc_nxt = acc_sum[ACC_W-1:0];
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_nxt = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  // Hold ratio, previous angle and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= RATIO_RESET;
      prev_r  <= '0;
      acc_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        ratio_r <= cfg_wr_data;
      end
      if (state_r == ST_UNW) begin
        prev_r <= angle;
      end
      if (load) begin
        acc_r <= acc_nxt;
      end
    end
  end

  // Working registers of the sequence
  always_ff @(posedge clk) begin
    if (q_pop) begin
      n_r       <= n_nxt;
      speed_r   <= q_entry.speed;
      cur_neg_r <= q_entry.cur_neg;
      cur_mag_r <= q_entry.cur_mag;
      temp_r    <= q_entry.temp;
    end
    if (state_r == ST_DIV) begin
      prod_r   <= (N_W+R_W)'(n_r) * (N_W+R_W)'(DIV_RECIP);
      cur_ma_r <= cur_neg_r ? -$signed(16'(cur_mag_ma)) : $signed(16'(cur_mag_ma));
    end
    if (state_r == ST_UNW) begin
      angle_r <= angle;
      delta_r <= DLT_W'(diff_unw);
      dneg_r  <= diff_unw[ANG_W];
      sprod_r <= 32'(dmag[15:0]) * 32'(ratio_r);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_angle_r <= angle_r;
      out_delta_r <= delta_r;
      out_shaft_r <= shaft;
      out_total_r <= TOT_W'(acc_nxt);
      out_speed_r <= speed_r;
      out_cur_r   <= cur_ma_r;
      out_temp_r  <= temp_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_rotor_angle       = out_angle_r;
  assign out_rotor_delta       = out_delta_r;
  assign out_shaft_delta       = out_shaft_r;
  assign out_shaft_angle_total = out_total_r;
  assign out_speed_rpm         = out_speed_r;
  assign out_current_ma        = out_cur_r;
  assign out_temperature       = out_temp_r;

`ifndef NO_ASSERTIONS
  a_div_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> ($past(state_r) == ST_IDLE))
    else $error("divide step entered without a popped beat");

  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> $stable(acc_r))
    else $error("accumulator moved without a result load");

  a_prev_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (prev_r == out_rotor_angle))
    else $error("previous angle differs from delivered rotor angle");
`endif

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mefd_pkg::*;

  // One decoded feedback beat, at the widths of the result ports
  typedef struct packed {
    logic [16:0]        rotor_angle;
    logic signed [16:0] rotor_delta;
    logic signed [16:0] shaft_delta;
    logic signed [47:0] shaft_angle_total;
    logic signed [15:0] speed_rpm;
    logic signed [15:0] current_ma;
    logic [7:0]         temperature;
  } feedback_t;

  // One raw feedback frame, bytes paired as they sit on the bus
  typedef struct packed {
    logic [15:0] count;
    logic [15:0] speed;
    logic [15:0] current;
    logic [7:0]  temp;
  } frame_t;

  // Directed row: frame plus an optional hand-written expectation
  typedef struct packed {
    frame_t    frame;
    logic      typed;
    feedback_t want;
  } frame_row_t;

  localparam feedback_t NO_WANT = '0;
  localparam int        N_DIRECTED = 19;
  localparam int        N_PHASES = 7;
  localparam int        PHASE_FRAMES = 215;

  localparam frame_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // First frame after reset, everything zero
    '{'{16'h0000, 16'h0000, 16'h0000, 8'h00}, 1'b1,
      '{17'd0, 17'sd0, 17'sd0, 48'sd0, 16'sd0, 16'sd0, 8'd0}},
    // Full-scale count wraps to zero delta; top speed, top current, hot
    '{'{16'h1FFF, 16'h7FFF, 16'h4000, 8'hFF}, 1'b1,
      '{17'd92160, 17'sd0, 17'sd0, 48'sd0, 16'sd32767, 16'sd20000, 8'd255}},
    // Count saturates; most negative speed; current clamps low
    '{'{16'hFFFF, 16'h8000, 16'h8000, 8'h00}, 1'b1,
      '{17'd92160, 17'sd0, 17'sd0, 48'sd0, -16'sd32768, -16'sd20000, 8'd0}},
    // Count one past the top saturates; current clamps high
    '{'{16'h2000, 16'hFFFF, 16'h7FFF, 8'h80}, 1'b1,
      '{17'd92160, 17'sd0, 17'sd0, 48'sd0, -16'sd1, 16'sd20000, 8'd128}},
    // Back to zero: full negative turn unwraps to zero delta
    '{'{16'h0000, 16'h0001, 16'hC000, 8'h01}, 1'b1,
      '{17'd0, 17'sd0, 17'sd0, 48'sd0, 16'sd1, -16'sd20000, 8'd1}},
    '{'{16'h0001, 16'h1234, 16'h0001, 8'h19}, 1'b0, NO_WANT},
    '{'{16'h0FFF, 16'h0000, 16'h0100, 8'h20}, 1'b0, NO_WANT},
    '{'{16'h0000, 16'h0000, 16'hFF00, 8'h20}, 1'b0, NO_WANT},
    '{'{16'h1000, 16'h0000, 16'h0000, 8'h00}, 1'b0, NO_WANT},
    '{'{16'h0000, 16'h0000, 16'h0000, 8'h00}, 1'b0, NO_WANT},
    '{'{16'h0FFF, 16'h0000, 16'h0000, 8'h00}, 1'b0, NO_WANT},
    '{'{16'h1FFE, 16'h0000, 16'h0000, 8'h00}, 1'b0, NO_WANT},
    '{'{16'h0001, 16'h0000, 16'h0000, 8'h00}, 1'b0, NO_WANT},
    '{'{16'h1FFF, 16'h0000, 16'h0000, 8'h00}, 1'b0, NO_WANT},
    '{'{16'h4000, 16'h5555, 16'h3FFF, 8'hAA}, 1'b0, NO_WANT},
    '{'{16'h0800, 16'hAAAA, 16'hC001, 8'h55}, 1'b0, NO_WANT},
    '{'{16'h1FFF, 16'h0000, 16'h4001, 8'h7F}, 1'b0, NO_WANT},
    '{'{16'h0000, 16'h0000, 16'hBFFF, 8'h00}, 1'b0, NO_WANT},
    '{'{16'h1234, 16'h0000, 16'h0000, 8'hFE}, 1'b0, NO_WANT}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  frame_t      in_frame = '0;
  logic        out_stall = 1'b0;

  logic               in_stall;
  logic               out_valid;
  logic [16:0]        out_rotor_angle;
  logic signed [16:0] out_rotor_delta;
  logic signed [16:0] out_shaft_delta;
  logic signed [47:0] out_shaft_angle_total;
  logic signed [15:0] out_speed_rpm;
  logic signed [15:0] out_current_ma;
  logic [7:0]         out_temperature;

  // Decoder mirror: previous angle, shaft accumulator, gear ratio
  logic [16:0] last_angle = '0;
  longint      shaft_accum = 0;
  logic [15:0] ratio_now = RATIO_RESET;

  feedback_t pending_fb[$];
  int        mismatch_count = 0;
  int        stall_left = 0;
  logic [15:0] last_count = '0;

  motor_encoder_feedback_decoder_unit dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_frame_byte0        (in_frame.count[15:8]),
    .in_frame_byte1        (in_frame.count[7:0]),
    .in_frame_byte2        (in_frame.speed[15:8]),
    .in_frame_byte3        (in_frame.speed[7:0]),
    .in_frame_byte4        (in_frame.current[15:8]),
    .in_frame_byte5        (in_frame.current[7:0]),
    .in_frame_byte6        (in_frame.temp),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_rotor_angle       (out_rotor_angle),
    .out_rotor_delta       (out_rotor_delta),
    .out_shaft_delta       (out_shaft_delta),
    .out_shaft_angle_total (out_shaft_angle_total),
    .out_speed_rpm         (out_speed_rpm),
    .out_current_ma        (out_current_ma),
    .out_temperature       (out_temperature)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Round v * mul / div to nearest, ties away from zero
  function automatic longint round_scale(longint v, longint mul, longint div);
    longint mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q = (mag * mul + div / 2) / div;
    return (v < 0) ? -q : q;
  endfunction

  // Decode one frame and advance the mirrored unwrap and accumulator state
  function automatic feedback_t decode_frame(frame_t f);
    longint    acc_hi;
    longint    acc_lo;
    longint    count;
    longint    angle;
    longint    delta;
    longint    shaft;
    longint    current;
    feedback_t r;
    acc_hi = (longint'(1) <<< (ACC_W - 1)) - 1;
    acc_lo = -acc_hi - 1;
    count = longint'(f.count);
    if (count > ENC_MAX) count = ENC_MAX;
    angle = (count * FULL_TURN + ENC_MAX / 2) / ENC_MAX;
    delta = angle - longint'(last_angle);
    if (delta > HALF_TURN) delta -= FULL_TURN;
    else if (delta < -HALF_TURN) delta += FULL_TURN;
    last_angle = 17'(angle);
    shaft = round_scale(delta, longint'(ratio_now), 65536);
    if (shaft > 0 && shaft_accum > acc_hi - shaft) shaft_accum = acc_hi;
    else if (shaft < 0 && shaft_accum < acc_lo - shaft) shaft_accum = acc_lo;
    else shaft_accum += shaft;
    current = longint'($signed(f.current));
    if (current > CUR_LIMIT) current = CUR_LIMIT;
    else if (current < -CUR_LIMIT) current = -CUR_LIMIT;
    r.rotor_angle = 17'(angle);
    r.rotor_delta = 17'(delta);
    r.shaft_delta = 17'(shaft);
    r.shaft_angle_total = 48'(shaft_accum);
    r.speed_rpm = $signed(f.speed);
    r.current_ma = 16'(round_scale(current, CUR_FULL_MA, CUR_LIMIT));
    r.temperature = f.temp;
    return r;
  endfunction

  // Motion around the last count, plus random counts, jumps and junk counts
  function automatic frame_t random_frame();
    frame_t f;
    int     pick;
    int     step;
    pick = $urandom_range(0, 99);
    step = 0;
    if (pick < 40) begin
      step = int'($urandom_range(0, 600)) - 300;
      f.count = 16'((int'(last_count) + 8192 + step) % 8192);
    end else if (pick < 65) begin
      f.count = 16'($urandom_range(0, ENC_MAX));
    end else if (pick < 75) begin
      step = int'($urandom_range(4088, 4104));
      if ($urandom_range(0, 1) == 0) step = -step;
      f.count = 16'((int'(last_count) + 8192 + step) % 8192);
    end else if (pick < 85) begin
      f.count = 16'($urandom);
    end else if (pick < 92) begin
      case ($urandom_range(0, 3))
        0:       f.count = 16'h0000;
        1:       f.count = 16'h1FFF;
        2:       f.count = 16'h2000;
        default: f.count = 16'hFFFF;
      endcase
    end else if ($urandom_range(0, 1) == 0) begin
      f.count = 16'($urandom_range(8185, 8191));
    end else begin
      f.count = 16'($urandom_range(0, 6));
    end
    last_count = (f.count > 16'(ENC_MAX)) ? 16'(ENC_MAX) : f.count;

    f.speed = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      f.current = 16'(int'($urandom_range(0, 2 * CUR_LIMIT)) - CUR_LIMIT);
    end else if (pick < 80) begin
      f.current = 16'($urandom);
    end else begin
      case ($urandom_range(0, 7))
        0:       f.current = 16'h4000;
        1:       f.current = 16'h4001;
        2:       f.current = 16'hC000;
        3:       f.current = 16'hBFFF;
        4:       f.current = 16'h7FFF;
        5:       f.current = 16'h8000;
        6:       f.current = 16'h0100;
        default: f.current = 16'hFF00;
      endcase
    end
    f.temp = 8'($urandom_range(0, 255));
    return f;
  endfunction

  // Sender gap: mostly none or short, a few long
  function automatic int pick_gap(bit calm);
    int pick;
    if (calm) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one frame, hold it until taken, then record what it should decode to
  task automatic send_frame(frame_t f, logic typed, feedback_t want, int gap);
    feedback_t p;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frame <= f;
    do @(posedge clk); while (in_stall);
    p = decode_frame(f);
    pending_fb.push_back(typed ? want : p);
  endtask

  // Drop valid and hold until every expected beat has come out
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_fb.size() != 0) @(posedge clk);
  endtask

  task automatic write_ratio(logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    ratio_now = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Receiver back-pressure: bursts of stall of random length, some quiet stretches
  always @(posedge clk) begin
    int pick;
    if (stall_left == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(1, 8);
      end else if (pick < 85) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(1, 3);
      end else if (pick < 95) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(10, 40);
      end else begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(50, 200);
      end
    end else begin
      stall_left = stall_left - 1;
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    feedback_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_fb.size() == 0) begin
        $error("result beat with no frame outstanding");
        mismatch_count++;
      end else begin
        w = pending_fb.pop_front();
        if (out_rotor_angle !== w.rotor_angle) begin
          $error("rotor_angle: expected %0d, got %0d", w.rotor_angle, out_rotor_angle);
          mismatch_count++;
        end
        if (out_rotor_delta !== w.rotor_delta) begin
          $error("rotor_delta: expected %0d, got %0d", w.rotor_delta, out_rotor_delta);
          mismatch_count++;
        end
        if (out_shaft_delta !== w.shaft_delta) begin
          $error("shaft_delta: expected %0d, got %0d", w.shaft_delta, out_shaft_delta);
          mismatch_count++;
        end
        if (out_shaft_angle_total !== w.shaft_angle_total) begin
          $error("shaft_angle_total: expected %0d, got %0d",
                 w.shaft_angle_total, out_shaft_angle_total);
          mismatch_count++;
        end
        if (out_speed_rpm !== w.speed_rpm) begin
          $error("speed_rpm: expected %0d, got %0d", w.speed_rpm, out_speed_rpm);
          mismatch_count++;
        end
        if (out_current_ma !== w.current_ma) begin
          $error("current_ma: expected %0d, got %0d", w.current_ma, out_current_ma);
          mismatch_count++;
        end
        if (out_temperature !== w.temperature) begin
          $error("temperature: expected %0d, got %0d", w.temperature, out_temperature);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [15:0] phase_ratio [N_PHASES];
    bit          calm;
    phase_ratio[0] = 16'hFFFF;
    phase_ratio[1] = 16'h0001;
    phase_ratio[2] = 16'h0000;
    phase_ratio[3] = 16'h8000;
    phase_ratio[4] = 16'($urandom_range(2, 65534));
    phase_ratio[5] = 16'($urandom_range(2, 65534));
    phase_ratio[6] = RATIO_RESET;
    calm = 1'b0;

    // Hold reset, then release it
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at the reset ratio
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_frame(DIRECTED_ROWS[i].frame, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want,
                 pick_gap(1'b0));
    end
    wait_drain();

    // Random frames, one ratio setting per phase, written only when drained
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_ratio(phase_ratio[ph]);
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        if (n % 40 == 0) calm = ($urandom_range(0, 4) == 0);
        if (n == PHASE_FRAMES / 2) wait_drain();
        send_frame(random_frame(), 1'b0, NO_WANT, pick_gap(calm));
      end
      wait_drain();
    end

    // Let any stray beat surface before judging
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog on a hung handshake
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
